// ===== rtl/core/magnitude_and_phase_extract_core_assert.svh =====
// Assertion macros for the magnitude and phase extract core.
`ifndef MAGNITUDE_AND_PHASE_EXTRACT_CORE_ASSERT_SVH
`define MAGNITUDE_AND_PHASE_EXTRACT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MPE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off during reset.
`define MPE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/mpe_pkg.sv =====
// Package: fixed constants and angle table for the magnitude and phase extract core.
package mpe_pkg;

	// alpha and beta truncated to 16 fraction bits
	localparam longint ALPHA_Q16 = 64'sd62942;
	localparam longint BETA_Q16  = 64'sd26071;
	localparam int     COEF_W    = 16;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	localparam int ENERGY_W = 32;
	localparam int INDEX_W  = 8;
	localparam int PHASE_W  = 20;
	localparam int MAG_W    = 24;
	localparam int ATAN_DEPTH = 24;

	// atan(2^-i), 30 fraction bits
	localparam longint ATAN_Q30 [ATAN_DEPTH] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
		64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
		64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
		64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
		64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
		64'sd1024,      64'sd512,       64'sd256,       64'sd128
	};

	// round half up from 30 fraction bits to pf fraction bits
	function automatic longint to_phase(longint q30, int pf);
		longint bias;
		bias = 64'sd1 <<< (29 - pf);
		return (q30 + bias) >>> (30 - pf);
	endfunction

endpackage

// ===== rtl/core/mpe_front.sv =====
// Front end: quadrant pre-rotation, max/min of magnitudes, coefficient products, index.
module mpe_front #(
	parameter int SAMPLE_W = 24,
	parameter int XW       = 27,
	parameter int ZW       = 20,
	parameter int PF       = 17,
	parameter int PW       = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_W-1:0]          gamma_re,
	input  logic signed [SAMPLE_W-1:0]          gamma_im,
	input  logic [mpe_pkg::ENERGY_W-1:0]        window_energy,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [XW-1:0]                x_out,
	output logic signed [XW-1:0]                y_out,
	output logic signed [ZW-1:0]                z_out,
	output logic [PW-1:0]                       prod_a,
	output logic [PW-1:0]                       prod_b,
	output logic [mpe_pkg::ENERGY_W-1:0]        energy_out,
	output logic [mpe_pkg::INDEX_W-1:0]         index_out
);

	localparam logic signed [ZW-1:0] HALF_PI =
		ZW'(mpe_pkg::to_phase(mpe_pkg::HALF_PI_Q30, PF));
	localparam logic [mpe_pkg::COEF_W-1:0] ALPHA = mpe_pkg::COEF_W'(mpe_pkg::ALPHA_Q16);
	localparam logic [mpe_pkg::COEF_W-1:0] BETA  = mpe_pkg::COEF_W'(mpe_pkg::BETA_Q16);

	logic [mpe_pkg::INDEX_W-1:0] index_q;

	logic                         v_s1, rdy_s1;
	logic signed [XW-1:0]         x_s1, y_s1;
	logic signed [ZW-1:0]         z_s1;
	logic [SAMPLE_W-1:0]          mx_s1, mn_s1;
	logic [mpe_pkg::ENERGY_W-1:0] e_s1;
	logic [mpe_pkg::INDEX_W-1:0]  idx_s1;

	logic                         v_s2, rdy_s2;

	logic [SAMPLE_W-1:0]  ax, ay;
	logic signed [XW-1:0] re_e, im_e, x_pre, y_pre;
	logic signed [ZW-1:0] z_pre;
	logic                 accept;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign accept   = in_valid && rdy_s1;
	assign out_valid = v_s2;

	// abs of the most negative code reads as 2^(W-1) unsigned
	assign ax   = gamma_re[SAMPLE_W-1] ? SAMPLE_W'(-gamma_re) : gamma_re;
	assign ay   = gamma_im[SAMPLE_W-1] ? SAMPLE_W'(-gamma_im) : gamma_im;
	assign re_e = XW'(gamma_re);
	assign im_e = XW'(gamma_im);

	always_comb begin
		x_pre = re_e;
		y_pre = im_e;
		z_pre = '0;
		if (gamma_re[SAMPLE_W-1]) begin
			if (!gamma_im[SAMPLE_W-1]) begin
				x_pre = im_e;
				y_pre = -re_e;
				z_pre = HALF_PI;
			end else begin
				x_pre = -im_e;
				y_pre = re_e;
				z_pre = -HALF_PI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (accept) index_q <= index_q + 1'b1;
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= x_pre;
			y_s1   <= y_pre;
			z_s1   <= z_pre;
			mx_s1  <= (ax > ay) ? ax : ay;
			mn_s1  <= (ax > ay) ? ay : ax;
			e_s1   <= window_energy;
			idx_s1 <= index_q;
		end
		if (v_s1 && rdy_s2) begin
			x_out      <= x_s1;
			y_out      <= y_s1;
			z_out      <= z_s1;
			prod_a     <= PW'(mx_s1) * PW'(ALPHA);
			prod_b     <= PW'(mn_s1) * PW'(BETA);
			energy_out <= e_s1;
			index_out  <= idx_s1;
		end
	end

endmodule

// ===== rtl/core/mpe_cell.sv =====
// One CORDIC vectoring cell: a fixed-shift micro-rotation and its pipeline register.
module mpe_cell #(
	parameter int XW     = 27,
	parameter int ZW     = 20,
	parameter int PF     = 17,
	parameter int SIDE_W = 120,
	parameter int STAGE  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_in,
	output logic                 ready_in,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 valid_out,
	input  logic                 ready_out,
	output logic signed [XW-1:0] x_s1,
	output logic signed [XW-1:0] y_s1,
	output logic signed [ZW-1:0] z_s1,
	output logic [SIDE_W-1:0]    side_s1
);

	localparam logic signed [ZW-1:0] ANGLE =
		ZW'(mpe_pkg::to_phase(mpe_pkg::ATAN_Q30[STAGE], PF));

	logic                 v_s1;
	logic signed [XW-1:0] xs, ys, x_nx, y_nx;
	logic signed [ZW-1:0] z_nx;

	assign ready_in  = !v_s1 || ready_out;
	assign valid_out = v_s1;
	assign xs = x_in >>> STAGE;
	assign ys = y_in >>> STAGE;

	// rotate toward the x axis, direction from the sign of y
	always_comb begin
		if (!y_in[XW-1]) begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + ANGLE;
		end else begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_in) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in && ready_in) begin
			x_s1    <= x_nx;
			y_s1    <= y_nx;
			z_s1    <= z_nx;
			side_s1 <= side_in;
		end
	end

endmodule

// ===== rtl/core/magnitude_and_phase_extract_core.sv =====
// Top level: front end, chain of CORDIC cells and output register for magnitude and phase.
// Pipeline: front-end registers, a register in each CORDIC cell, then the output register
//   that takes the magnitude sum.
// Throughput: one word per cycle while out_ready is high; each stage has its own valid
//   bit and takes a new word if empty or if its successor moves; bubbles close in a stall.
// Reset: arst_n clears all valid bits and the sample index; the datapath is not reset.
module magnitude_and_phase_extract_core #(
	parameter int ITERATIONS          = 16,
	parameter int SAMPLE_WIDTH        = 24,
	parameter int PHASE_FRACTION_BITS = 17
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]   gamma_re,
	input  logic signed [SAMPLE_WIDTH-1:0]   gamma_im,
	input  logic [mpe_pkg::ENERGY_W-1:0]     window_energy,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mpe_pkg::MAG_W-1:0]        magnitude,
	output logic signed [mpe_pkg::PHASE_W-1:0] phase,
	output logic [mpe_pkg::ENERGY_W-1:0]     energy_out,
	output logic [mpe_pkg::INDEX_W-1:0]      sample_index
);

	`include "magnitude_and_phase_extract_core_assert.svh"

	// x stays below about 2.33 * 2^(W-1) after gain; two guard bits plus sign
	localparam int XW = SAMPLE_WIDTH + 3;
	// |z| stays under pi/2 + sum of the angle table, below 4 rad
	localparam int ZW = PHASE_FRACTION_BITS + 3;
	// max/min times a 16-bit coefficient
	localparam int PW = SAMPLE_WIDTH + mpe_pkg::COEF_W;
	localparam int SIDE_W = mpe_pkg::ENERGY_W + mpe_pkg::INDEX_W + 2 * PW;
	localparam int ZE = (ZW > mpe_pkg::PHASE_W) ? ZW : mpe_pkg::PHASE_W;
	localparam int MW = (SAMPLE_WIDTH + 1 > mpe_pkg::MAG_W) ? SAMPLE_WIDTH + 1
		: mpe_pkg::MAG_W;

	// chain taps: index 0 is the front end output, index ITERATIONS the last cell
	logic                 cv [ITERATIONS+1];
	logic                 cr [ITERATIONS+1];
	logic signed [XW-1:0] cx [ITERATIONS+1];
	logic signed [XW-1:0] cy [ITERATIONS+1];
	logic signed [ZW-1:0] cz [ITERATIONS+1];
	logic [SIDE_W-1:0]    cs [ITERATIONS+1];

	logic [PW-1:0]                fa, fb;
	logic [mpe_pkg::ENERGY_W-1:0] fe;
	logic [mpe_pkg::INDEX_W-1:0]  fi;

	mpe_front #(
		.SAMPLE_W (SAMPLE_WIDTH),
		.XW       (XW),
		.ZW       (ZW),
		.PF       (PHASE_FRACTION_BITS),
		.PW       (PW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.gamma_re      (gamma_re),
		.gamma_im      (gamma_im),
		.window_energy (window_energy),
		.out_valid     (cv[0]),
		.out_ready     (cr[0]),
		.x_out         (cx[0]),
		.y_out         (cy[0]),
		.z_out         (cz[0]),
		.prod_a        (fa),
		.prod_b        (fb),
		.energy_out    (fe),
		.index_out     (fi)
	);

	// energy, index and both products ride along the chain untouched
	assign cs[0] = {fe, fi, fa, fb};

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		mpe_cell #(
			.XW     (XW),
			.ZW     (ZW),
			.PF     (PHASE_FRACTION_BITS),
			.SIDE_W (SIDE_W),
			.STAGE  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (cv[i]),
			.ready_in  (cr[i]),
			.x_in      (cx[i]),
			.y_in      (cy[i]),
			.z_in      (cz[i]),
			.side_in   (cs[i]),
			.valid_out (cv[i+1]),
			.ready_out (cr[i+1]),
			.x_s1      (cx[i+1]),
			.y_s1      (cy[i+1]),
			.z_s1      (cz[i+1]),
			.side_s1   (cs[i+1])
		);
	end

	// output stage: alpha*max + beta*min, floor to 0 fraction bits (an integer)
	logic                 out_v_q;
	logic [PW:0]          mag_sum;
	logic [MW-1:0]        mag_wide;
	logic signed [ZE-1:0] z_wide;
	logic [SIDE_W-1:0]    last_side;

	assign last_side = cs[ITERATIONS];
	assign mag_sum   = {1'b0, last_side[2*PW-1:PW]} + {1'b0, last_side[PW-1:0]};
	assign mag_wide  = MW'(mag_sum[PW:mpe_pkg::COEF_W]);
	assign z_wide    = ZE'(cz[ITERATIONS]);

	assign cr[ITERATIONS] = !out_v_q || out_ready;
	assign out_valid      = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cr[ITERATIONS]) begin
			out_v_q <= cv[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (cv[ITERATIONS] && cr[ITERATIONS]) begin
			magnitude    <= mag_wide[mpe_pkg::MAG_W-1:0];
			phase        <= z_wide[mpe_pkg::PHASE_W-1:0];
			energy_out   <= last_side[SIDE_W-1 -: mpe_pkg::ENERGY_W];
			sample_index <= last_side[2*PW +: mpe_pkg::INDEX_W];
		end
	end

	// a held output word backs up into the last cell when it is full too
	`MPE_ASSERT_IMPL(a_stall_reaches_chain, out_v_q && !out_ready && cv[ITERATIONS], !cr[ITERATIONS])
	// a full last cell always drains into an empty output register
	`MPE_ASSERT_NEXT(a_chain_drains, cv[ITERATIONS] && !out_v_q, out_v_q)
	// consecutive output words carry consecutive indexes: nothing lost or repeated
	`MPE_ASSERT_NEXT(a_index_in_order, out_valid && out_ready,
		!out_valid || (sample_index == $past(sample_index) + 1'b1))

endmodule
